// ----- rtl/xdre_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xdre_pkg
// Shared types and constants for the xor delta run encoder.
// ----------------------------------------------------------------------------
package xdre_pkg;

   // width of a run length (covers a maximum run of up to 63)
   localparam int CNT_W = 6;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // control byte flag for a zero run
   localparam logic [7:0] ZERO_RUN_FLAG = 8'h80;

   // one classified item, handed from front to back
   typedef struct packed {
      logic [7:0]       xor_byte;
      logic             close_old;
      logic [CNT_W-1:0] old_len;
      logic [CNT_W-1:0] new_len;
      logic             close_new;
      logic             final_pos;
   } entry_type;

   // run control byte: kind flag ORed with length minus one
   function automatic logic [7:0] ctl_byte(input logic is_zero, input logic [CNT_W-1:0] len);
      logic [CNT_W-1:0] len_m1;
      len_m1 = len - CNT_W'(1);
      ctl_byte = (is_zero ? ZERO_RUN_FLAG : 8'h00) | {{(8 - CNT_W){1'b0}}, len_m1};
   endfunction

endpackage
`default_nettype wire

// ----- rtl/xor_delta_run_encoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xor_delta_run_encoder
// Streaming xor delta run length encoder: front classifies, back emits.
// ----------------------------------------------------------------------------
// Path: with the back idle, an item is popped in IDLE; the control byte of
//   an older run is loaded in OLD_CTL, of its own run in NEW_CTL after WRITE.
// The back takes a new item only in IDLE. An item that closes no run passes
//   IDLE and WRITE; each literal passes LIT_RD, then LIT_OUT (read, then output).
// A 4-entry queue lets the front accept while the back drains a run.
// Reset clears run state, queue and output valid, not the literal memory.
// ----------------------------------------------------------------------------
module xor_delta_run_encoder #(
   parameter int MAX_RUN = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [7:0] base_byte, [15:8] current_byte
   input  wire logic        req_tlast,   // final_position
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_byte
   output logic [1:0]       rsp_tuser,   // [0] is_control, [1] last_of_item
   output logic             rsp_tlast    // end_of_stream
);
   import xdre_pkg::*;

   entry_type push_entry;
   entry_type head_entry;
   logic      q_push;
   logic      q_full;
   logic      q_pop;
   logic      q_not_empty;
   logic      is_control;
   logic      last_of_item;

   xdre_front #(
      .MAX_RUN(MAX_RUN)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .base_byte      (req_tdata[7:0]),
      .current_byte   (req_tdata[15:8]),
      .final_position (req_tlast),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_entry        (push_entry)
   );

   xdre_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head_entry (head_entry)
   );

   xdre_back #(
      .MAX_RUN(MAX_RUN)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_not_empty),
      .q_entry           (head_entry),
      .q_pop             (q_pop),
      .out_valid         (rsp_tvalid),
      .out_ready         (rsp_tready),
      .out_byte          (rsp_tdata),
      .out_is_control    (is_control),
      .out_last_of_item  (last_of_item),
      .out_end_of_stream (rsp_tlast)
   );

   assign rsp_tuser = {last_of_item, is_control};

endmodule
`default_nettype wire

// ----- rtl/xdre_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xdre_front
// Accepts items, forms the xor byte and tracks the open run, deciding which
// runs close on each item.
// ----------------------------------------------------------------------------
module xdre_front #(
   parameter int MAX_RUN = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire logic [7:0]          base_byte,
   input  wire logic [7:0]          current_byte,
   input  wire logic                final_position,
   input  wire logic                q_full,
   output logic                     q_push,
   output xdre_pkg::entry_type      q_entry
);
   import xdre_pkg::*;

   logic             run_is_zero_ff, run_is_zero_in;
   logic [CNT_W-1:0] run_count_ff, run_count_in;
   logic [7:0]       xor_byte;
   logic             is_zero;
   logic             close_old;
   logic [CNT_W-1:0] start_count;
   logic [CNT_W-1:0] new_len;
   logic             close_new;

   // classify the incoming byte against the open run
   always_comb begin
      xor_byte    = base_byte ^ current_byte;
      is_zero     = (xor_byte == 8'h00);
      close_old   = (run_count_ff != '0) && (run_is_zero_ff != is_zero);
      start_count = close_old ? '0 : run_count_ff;
      new_len     = start_count + CNT_W'(1);
      close_new   = (new_len >= CNT_W'(MAX_RUN)) || final_position;

      in_ready = !q_full;
      q_push   = in_valid && !q_full;

      q_entry.xor_byte  = xor_byte;
      q_entry.close_old = close_old;
      q_entry.old_len   = run_count_ff;
      q_entry.new_len   = new_len;
      q_entry.close_new = close_new;
      q_entry.final_pos = final_position;

      run_count_in   = run_count_ff;
      run_is_zero_in = run_is_zero_ff;
      if (q_push) begin
         run_count_in   = close_new ? '0 : new_len;
         run_is_zero_in = close_new ? 1'b0 : is_zero;
      end
   end

   // open run state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_count_ff   <= '0;
         run_is_zero_ff <= 1'b0;
      end else begin
         run_count_ff   <= run_count_in;
         run_is_zero_ff <= run_is_zero_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/xdre_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xdre_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module xdre_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire xdre_pkg::entry_type push_entry,
   output logic                     full,
   input  wire logic                pop,
   output logic                     not_empty,
   output xdre_pkg::entry_type      head_entry
);
   import xdre_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   entry_type     slot_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   fill_ff, fill_in;
   logic          do_push, do_pop;

   // pointer and fill bookkeeping
   always_comb begin
      full       = (fill_ff == (PW + 1)'(QUEUE_DEPTH));
      not_empty  = (fill_ff != '0);
      head_entry = slot_ff[rd_ptr_ff];
      do_push    = push && !full;
      do_pop     = pop && not_empty;
      wr_ptr_in  = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      fill_in    = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (PW + 1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (PW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/xdre_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xdre_back
// Carries out classified items: emits closed runs as control and literal
// bytes and keeps the literal memory of the open nonzero run.
// ----------------------------------------------------------------------------
module xdre_back #(
   parameter int MAX_RUN = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  wire xdre_pkg::entry_type q_entry,
   output logic                     q_pop,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output logic [7:0]               out_byte,
   output logic                     out_is_control,
   output logic                     out_last_of_item,
   output logic                     out_end_of_stream
);
   import xdre_pkg::*;

   localparam int AW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

   typedef enum logic [2:0] {
      IDLE,
      OLD_CTL,
      LIT_RD,
      LIT_OUT,
      WRITE,
      NEW_CTL
   } state_type;

   state_type        state_ff;
   entry_type        ent_ff;
   logic [CNT_W-1:0] idx_ff;
   logic             new_phase_ff;
   logic             valid_ff;
   logic [7:0]       byte_ff;
   logic             ctl_ff;
   logic             last_ff;
   logic             eos_ff;

   logic [7:0]       lit_mem_ff [MAX_RUN];
   logic [7:0]       lit_q_ff;

   logic             slot_free;
   logic             emit;
   logic             new_zero;
   logic [CNT_W-1:0] run_len;
   logic             last_lit;
   logic             mem_we;
   logic             mem_re;
   logic [CNT_W-1:0] wr_idx;

   // derived control
   always_comb begin
      slot_free = !valid_ff || out_ready;
      emit      = slot_free && (state_ff == OLD_CTL || state_ff == LIT_OUT ||
                                state_ff == NEW_CTL);
      new_zero  = (ent_ff.xor_byte == 8'h00);
      run_len   = new_phase_ff ? ent_ff.new_len : ent_ff.old_len;
      last_lit  = (idx_ff == run_len - CNT_W'(1));
      mem_we    = (state_ff == WRITE);
      mem_re    = (state_ff == LIT_RD);
      wr_idx    = ent_ff.new_len - CNT_W'(1);
      q_pop     = (state_ff == IDLE) && q_valid;
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         valid_ff     <= 1'b0;
         idx_ff       <= '0;
         new_phase_ff <= 1'b0;
      end else begin
         if (valid_ff && out_ready && !emit) begin
            valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (q_valid) begin
                  ent_ff       <= q_entry;
                  new_phase_ff <= 1'b0;
                  idx_ff       <= '0;
                  state_ff     <= q_entry.close_old ? OLD_CTL : WRITE;
               end
            end
            OLD_CTL: begin
               // old run has the opposite kind of the new byte
               if (slot_free) begin
                  valid_ff <= 1'b1;
                  byte_ff  <= ctl_byte(!new_zero, ent_ff.old_len);
                  ctl_ff   <= 1'b1;
                  last_ff  <= !new_zero && !ent_ff.close_new;
                  eos_ff   <= !new_zero && !ent_ff.close_new && ent_ff.final_pos;
                  idx_ff   <= '0;
                  state_ff <= new_zero ? LIT_RD : WRITE;
               end
            end
            LIT_RD: begin
               state_ff <= LIT_OUT;
            end
            LIT_OUT: begin
               if (slot_free) begin
                  valid_ff <= 1'b1;
                  byte_ff  <= lit_q_ff;
                  ctl_ff   <= 1'b0;
                  last_ff  <= last_lit && (new_phase_ff || !ent_ff.close_new);
                  eos_ff   <= last_lit && (new_phase_ff || !ent_ff.close_new)
                              && ent_ff.final_pos;
                  if (last_lit) begin
                     state_ff <= new_phase_ff ? IDLE : WRITE;
                  end else begin
                     idx_ff   <= idx_ff + CNT_W'(1);
                     state_ff <= LIT_RD;
                  end
               end
            end
            WRITE: begin
               state_ff <= ent_ff.close_new ? NEW_CTL : IDLE;
            end
            NEW_CTL: begin
               if (slot_free) begin
                  valid_ff     <= 1'b1;
                  byte_ff      <= ctl_byte(new_zero, ent_ff.new_len);
                  ctl_ff       <= 1'b1;
                  last_ff      <= new_zero;
                  eos_ff       <= new_zero && ent_ff.final_pos;
                  idx_ff       <= '0;
                  new_phase_ff <= 1'b1;
                  state_ff     <= new_zero ? IDLE : LIT_RD;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   // literal memory of the open run
   always_ff @(posedge clock) begin
      if (mem_we) begin
         lit_mem_ff[wr_idx[AW-1:0]] <= ent_ff.xor_byte;
      end
      if (mem_re) begin
         lit_q_ff <= lit_mem_ff[idx_ff[AW-1:0]];
      end
   end

   assign out_valid         = valid_ff;
   assign out_byte          = byte_ff;
   assign out_is_control    = ctl_ff;
   assign out_last_of_item  = last_ff;
   assign out_end_of_stream = eos_ff;

   // a literal is only shown after its memory read
   a_read_before_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == LIT_OUT) |-> ($past(state_ff) == LIT_RD || $past(state_ff) == LIT_OUT))
      else $error("literal output without a memory read");

   // the end of the stream is always the last byte of its item
   a_eos_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && eos_ff) |-> last_ff)
      else $error("end of stream without last of item");

   // an older run that closes is never empty
   a_old_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == OLD_CTL) |-> (ent_ff.old_len != '0))
      else $error("closing an empty run");

   // literal index stays inside the run
   a_idx_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == LIT_RD || state_ff == LIT_OUT) |-> (idx_ff < run_len))
      else $error("literal index past run length");

endmodule
`default_nettype wire

// ----- dv/xor_delta_run_encoder_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xor_delta_run_encoder_tb
// Stream testbench for the xor delta run encoder. A short directed sequence
// covers the byte extremes, kind changes, single-byte snapshots and runs that
// close on the final byte. Random snapshots made of zero and nonzero runs
// follow, some reaching the maximum run length. Each accepted position goes
// through a behavioral encoder in the scoreboard, and every output
// transaction is compared field by field with the oldest predicted byte.
// Backpressure and source gaps change between phases.
// ----------------------------------------------------------------------------
module xor_delta_run_encoder_tb;
   import xdre_pkg::*;

   localparam int MAX_RUN = 32;
   localparam int ITEMS_PER_PHASE = 33;

   // one byte of the encoded stream with its flags
   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_control;
      logic       last_of_item;
      logic       end_of_stream;
   } enc_byte_type;

   // behavioral encoder plus queue of predicted output bytes
   class encoding_scoreboard;
      enc_byte_type pending_bytes[$];
      enc_byte_type step_bytes[$];
      logic [7:0]   literal_store[MAX_RUN];
      bit           open_is_zero;
      int           open_len;
      int           error_count;
      int           position_count;
      int           byte_count;
      int           control_count;
      int           full_run_count;

      function new();
         open_is_zero   = 1'b0;
         open_len       = 0;
         error_count    = 0;
         position_count = 0;
         byte_count     = 0;
         control_count  = 0;
         full_run_count = 0;
      endfunction

      // emit the open run as control byte plus literals
      function void close_open_run();
         enc_byte_type e;
         logic [7:0]   ctl;
         if (open_len == 0) return;
         ctl = 8'(open_len - 1) & 8'h7F;
         if (open_is_zero) ctl = ctl | ZERO_RUN_FLAG;
         e = '{out_byte: ctl, is_control: 1'b1, last_of_item: 1'b0, end_of_stream: 1'b0};
         step_bytes.push_back(e);
         if (!open_is_zero) begin
            for (int i = 0; i < open_len; i++) begin
               e = '{out_byte: literal_store[i], is_control: 1'b0,
                     last_of_item: 1'b0, end_of_stream: 1'b0};
               step_bytes.push_back(e);
            end
         end
         if (open_len == MAX_RUN) full_run_count++;
         open_len     = 0;
         open_is_zero = 1'b0;
      endfunction

      // predict the bytes caused by one accepted position
      function void absorb_position(logic [7:0] base_b, logic [7:0] cur_b, logic fin);
         logic [7:0] delta;
         bit         is_zero;
         int         idx;
         delta   = base_b ^ cur_b;
         is_zero = (delta == 8'h00);
         position_count++;
         step_bytes.delete();
         if (open_len != 0 && open_is_zero != is_zero) close_open_run();
         if (open_len == 0) open_is_zero = is_zero;
         if (open_len < MAX_RUN) literal_store[open_len] = delta;
         open_len++;
         if (open_len >= MAX_RUN || fin) close_open_run();
         if (step_bytes.size() > 0) begin
            idx = step_bytes.size() - 1;
            step_bytes[idx].last_of_item  = 1'b1;
            step_bytes[idx].end_of_stream = fin;
         end
         foreach (step_bytes[i]) pending_bytes.push_back(step_bytes[i]);
      endfunction

      function void report(string what, enc_byte_type want, enc_byte_type got);
         error_count++;
         if (error_count <= 10) begin
            $display("%0t: %s: expected byte %02h ctl %b last %b eos %b,",
                     $realtime, what, want.out_byte, want.is_control,
                     want.last_of_item, want.end_of_stream);
            $display("   got byte %02h ctl %b last %b eos %b",
                     got.out_byte, got.is_control, got.last_of_item,
                     got.end_of_stream);
         end
      endfunction

      // compare one output transaction with the oldest prediction
      function void check_output_byte(enc_byte_type got);
         enc_byte_type want;
         byte_count++;
         if (got.is_control === 1'b1) control_count++;
         if (pending_bytes.size() == 0) begin
            want = '0;
            report("unexpected output", want, got);
            return;
         end
         want = pending_bytes.pop_front();
         if (got.out_byte !== want.out_byte || got.is_control !== want.is_control ||
             got.last_of_item !== want.last_of_item ||
             got.end_of_stream !== want.end_of_stream)
            report("mismatch", want, got);
      endfunction

      function int pending();
         return pending_bytes.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [7:0] base_byte, [15:8] current_byte
   logic        req_tlast = 1'b0; // final_position
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [7:0] out_byte
   logic [1:0]  rsp_tuser;        // [0] is_control, [1] last_of_item
   logic        rsp_tlast;        // end_of_stream

   encoding_scoreboard sb = new();
   int send_idle_pct = 20;
   int recv_idle_pct = 73;

   xor_delta_run_encoder #(.MAX_RUN(MAX_RUN)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 4 ns clock
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // result side: check accepted transactions, random backpressure
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_output_byte('{out_byte: rsp_tdata, is_control: rsp_tuser[0],
                                   last_of_item: rsp_tuser[1], end_of_stream: rsp_tlast});
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // drive one position and wait for its transaction
   task automatic send_position(logic [7:0] base_b, logic [7:0] cur_b, logic fin);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {cur_b, base_b};
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.absorb_position(base_b, cur_b, fin);
   endtask

   // position whose xor is zero or a chosen nonzero value
   task automatic send_delta(logic [7:0] delta, logic fin);
      logic [7:0] b;
      b = 8'($urandom);
      send_position(b, b ^ delta, fin);
   endtask

   // hold the source off until every predicted byte has come out
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // byte extremes, kind changes and single-byte snapshots
   task automatic directed_sequence();
      send_position(8'h00, 8'hFF, 1'b0);
      send_position(8'hFF, 8'hFF, 1'b0);
      send_position(8'hFF, 8'h00, 1'b1);
      send_position(8'h00, 8'h00, 1'b1);
      send_position(8'h5A, 8'hA5, 1'b1);
      send_delta(8'h01, 1'b0);
      send_delta(8'h80, 1'b0);
      send_delta(8'h00, 1'b1);
      send_delta(8'h00, 1'b0);
      send_delta(8'h00, 1'b0);
      send_delta(8'h00, 1'b1);
   endtask

   // random snapshots built from zero and nonzero runs
   task automatic random_phase(bit long_run, bit long_zero);
      int         sent;
      int         len;
      bit         zero_kind;
      bit         forced;
      logic [7:0] delta;
      logic       fin;
      sent   = 0;
      forced = long_run;
      while (sent < ITEMS_PER_PHASE) begin
         if (forced) begin
            // one run of at least the maximum length
            len       = $urandom_range(MAX_RUN, MAX_RUN + 1);
            zero_kind = long_zero;
         end else begin
            if ($urandom_range(0, 9) == 0) len = $urandom_range(MAX_RUN - 2, MAX_RUN);
            else len = $urandom_range(1, 6);
            zero_kind = 1'($urandom_range(0, 1));
         end
         if (len > ITEMS_PER_PHASE - sent) len = ITEMS_PER_PHASE - sent;
         for (int i = 0; i < len; i++) begin
            delta = zero_kind ? 8'h00 : 8'($urandom_range(1, 255));
            if (!forced && $urandom_range(0, 99) < 5) delta = 8'($urandom);
            fin = !forced && ($urandom_range(0, 99) < 4);
            if (i == len - 1 && $urandom_range(0, 3) == 0) fin = 1'b1;
            send_delta(delta, fin);
            sent++;
         end
         forced = 1'b0;
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_sequence();
      wait_for_drain();

      random_phase(1'b1, 1'b0);
      wait_for_drain();

      send_idle_pct = 73;
      recv_idle_pct = 20;
      random_phase(1'b0, 1'b0);
      wait_for_drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(1'b1, 1'b1);
      send_delta(8'h3C, 1'b1);
      wait_for_drain();
      repeat (40) @(posedge clock);

      $display("encoded %0d positions into %0d bytes (%0d control, %0d full-length runs)",
               sb.position_count, sb.byte_count, sb.control_count, sb.full_run_count);
      $display("under heavy backpressure, heavy source gaps and no stalls; %0d mismatches",
               sb.error_count);
      if (sb.error_count == 0 && sb.pending() == 0)
         $display("xor_delta_run_encoder_tb passed");
      else
         $display("xor_delta_run_encoder_tb failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("xor_delta_run_encoder_tb failed");
      $finish;
   end
endmodule

// ----- sim.f -----
rtl/xdre_pkg.sv
rtl/xdre_front.sv
rtl/xdre_queue.sv
rtl/xdre_back.sv
rtl/xor_delta_run_encoder.sv
dv/xor_delta_run_encoder_tb.sv
